@@ hdl/sps_pkg.sv @@
// Package for the segment/polyline intersection stream core.
// Types, constants and helpers shared by front, queue, back and top level.
// No dependencies.
`default_nettype none
package sps_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 63;
  localparam int COUNT_W      = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
  localparam int SIDE_W       = 35;
  localparam int Q_W          = 17;
  localparam int DIV_CNT_W    = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEG_AX      = 3'd0,
    CFG_SEG_AY      = 3'd1,
    CFG_SEG_BX      = 3'd2,
    CFG_SEG_BY      = 3'd3,
    CFG_CROSS_EPS   = 3'd4,
    CFG_JOIN_EPS_SQ = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic [62:0]        cross_eps;
    logic [31:0]        join_eps_sq;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic               has_edge;
    logic               first;
    logic               last;
  } edge_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               is_point;
    logic [COUNT_W-1:0] count;
    logic               last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIDE, ST_PROD, ST_PREP, ST_MULD, ST_DIVI,
    ST_DIV, ST_DIVF, ST_FILT, ST_DEC, ST_OUT
  } state_t;

  function automatic res_t mk_res(logic signed [15:0] x, logic signed [15:0] y,
                                  logic isp, logic [COUNT_W-1:0] cnt, logic lst);
    res_t r;
    r.x        = x;
    r.y        = y;
    r.is_point = isp;
    r.count    = cnt;
    r.last     = lst;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/sps_fifo.sv @@
// Two-entry queue of edge items between front and back.
// Depends on sps_pkg.
`default_nettype none
module sps_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sps_pkg::edge_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output sps_pkg::edge_t     pop_data
);
  import sps_pkg::*;

  edge_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;

  assign full      = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

endmodule
`default_nettype wire

@@ hdl/sps_front.sv @@
// Front end: accepts vertices, tracks the previous vertex and vertex count,
// and forms edge items for the queue. Depends on sps_pkg.
`default_nettype none
module sps_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_vertex_x,
  input  wire logic signed [15:0] in_vertex_y,
  input  wire logic               in_first_vertex,
  input  wire logic               in_last_vertex,
  input  wire logic               fifo_full,
  output logic                    push,
  output sps_pkg::edge_t          push_data
);
  import sps_pkg::*;

  logic signed [15:0] prev_x_r, prev_y_r, prev_x_nxt, prev_y_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [VCNT_W-1:0]  vcount_r, vcount_nxt;
  logic               hp;
  logic [VCNT_W-1:0]  vc;
  logic               in_range;

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  always_comb begin
    hp       = in_first_vertex ? 1'b0 : have_prev_r;
    vc       = in_first_vertex ? '0 : vcount_r;
    in_range = (vc < VCNT_W'(MAX_VERTICES));

    push_data.px       = prev_x_r;
    push_data.py       = prev_y_r;
    push_data.qx       = in_vertex_x;
    push_data.qy       = in_vertex_y;
    push_data.has_edge = hp && in_range;
    push_data.first    = in_first_vertex;
    push_data.last     = in_last_vertex;

    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    have_prev_nxt = have_prev_r;
    vcount_nxt    = vcount_r;
    if (push) begin
      have_prev_nxt = hp;
      vcount_nxt    = vc;
      if (in_range) begin
        prev_x_nxt    = in_vertex_x;
        prev_y_nxt    = in_vertex_y;
        have_prev_nxt = 1'b1;
        vcount_nxt    = vc + 1'b1;
      end
      if (in_last_vertex) begin
        have_prev_nxt = 1'b0;
        vcount_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      vcount_r    <= '0;
    end else begin
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      have_prev_r <= have_prev_nxt;
      vcount_r    <= vcount_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/sps_back.sv @@
// Back end: side tests, rejection, iterative division for the hit point,
// join filter, held point, end marker and output register. Depends on sps_pkg.
`default_nettype none
module sps_back (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire sps_pkg::cfg_t cfg,
  input  wire logic   fifo_valid,
  input  wire sps_pkg::edge_t fifo_data,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output sps_pkg::res_t out_res
);
  import sps_pkg::*;

  state_t                    state_r, state_nxt;
  logic [1:0]                step_r, step_nxt;
  edge_t                     cur_r, cur_nxt;
  logic signed [SIDE_W-1:0]  s_r [4];
  logic signed [SIDE_W-1:0]  s_nxt [4];
  logic                      rej_r, rej_nxt;
  logic [SIDE_W-1:0]         num_r, num_nxt, den_r, den_nxt;
  logic [51:0]               magx_r, magx_nxt, magy_r, magy_nxt;
  logic                      negx_r, negx_nxt, negy_r, negy_nxt;
  logic [52:0]               remx_r, remx_nxt, remy_r, remy_nxt, dsh_r, dsh_nxt;
  logic [Q_W-1:0]            qx_r, qx_nxt, qy_r, qy_nxt;
  logic [DIV_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                      hv_r, hv_nxt;
  logic signed [15:0]        hx_r, hx_nxt, hy_r, hy_nxt;
  logic                      closeh_r, closeh_nxt, closef_r, closef_nxt;
  logic signed [15:0]        pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic                      have_pend_r, have_pend_nxt;
  logic signed [15:0]        fk_x_r, fk_x_nxt, fk_y_r, fk_y_nxt;
  logic                      have_first_r, have_first_nxt;
  logic [COUNT_W-1:0]        kt_r, kt_nxt;
  logic signed [15:0]        hit_x_r, hit_x_nxt, hit_y_r, hit_y_nxt;
  logic                      have_hit_r, have_hit_nxt;
  res_t                      res_r [2];
  res_t                      res_nxt [2];
  logic [1:0]                res_n_r, res_n_nxt, res_i_r, res_i_nxt;
  res_t                      out_r, out_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // side value datapath
  logic signed [15:0]        sx1, sy1, sx2, sy2, spx, spy;
  logic signed [16:0]        d1x, d1y, d2x, d2y;
  logic signed [33:0]        sp1, sp2;
  logic signed [SIDE_W-1:0]  side_val;
  // product threshold
  logic signed [SIDE_W-1:0]  pa, pb, pa_neg, pb_neg;
  logic [33:0]               ma, mb;
  logic [67:0]               prod;
  logic                      prod_ge;
  // division set-up
  logic signed [35:0]        n36, d36;
  logic signed [16:0]        dab_x, dab_y;
  logic signed [52:0]        prodx, prody;
  logic                      bitx, bity;
  logic signed [17:0]        offx, offy;
  // join distances
  logic signed [16:0]        hdx, hdy, fdx, fdy;
  logic signed [33:0]        hdx2, hdy2, fdx2, fdy2;
  logic [34:0]               hsum, fsum;
  // decision
  logic                      keep, new_em, t_have_pend;
  logic [1:0]                n;
  logic [COUNT_W-1:0]        t_kt;
  logic                      slot_free;

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    sx1 = cur_r.px;
    sy1 = cur_r.py;
    sx2 = cur_r.qx;
    sy2 = cur_r.qy;
    spx = cfg.ax;
    spy = cfg.ay;
    unique case (step_r)
      2'd0: begin
        spx = cfg.ax;
        spy = cfg.ay;
      end
      2'd1: begin
        spx = cfg.bx;
        spy = cfg.by;
      end
      2'd2: begin
        sx1 = cfg.ax; sy1 = cfg.ay; sx2 = cfg.bx; sy2 = cfg.by;
        spx = cur_r.px;
        spy = cur_r.py;
      end
      2'd3: begin
        sx1 = cfg.ax; sy1 = cfg.ay; sx2 = cfg.bx; sy2 = cfg.by;
        spx = cur_r.qx;
        spy = cur_r.qy;
      end
      default: ;
    endcase
    d1x      = 17'(sx2) - 17'(sx1);
    d1y      = 17'(sy2) - 17'(sy1);
    d2x      = 17'(spx) - 17'(sx1);
    d2y      = 17'(spy) - 17'(sy1);
    sp1      = d1x * d2y;
    sp2      = d1y * d2x;
    side_val = SIDE_W'(sp1) - SIDE_W'(sp2);
  end

  always_comb begin
    pa      = step_r[0] ? s_r[2] : s_r[0];
    pb      = step_r[0] ? s_r[3] : s_r[1];
    pa_neg  = -pa;
    pb_neg  = -pb;
    ma      = pa[SIDE_W-1] ? pa_neg[33:0] : pa[33:0];
    mb      = pb[SIDE_W-1] ? pb_neg[33:0] : pb[33:0];
    prod    = ma * mb;
    if (pa == '0 || pb == '0) begin
      prod_ge = (cfg.cross_eps == '0);
    end else if (pa[SIDE_W-1] != pb[SIDE_W-1]) begin
      prod_ge = 1'b0;
    end else begin
      prod_ge = (prod >= 68'(cfg.cross_eps));
    end
  end

  always_comb begin
    dab_x = 17'(cfg.bx) - 17'(cfg.ax);
    dab_y = 17'(cfg.by) - 17'(cfg.ay);
    prodx = $signed({1'b0, num_r}) * dab_x;
    prody = $signed({1'b0, num_r}) * dab_y;
    bitx  = (remx_r >= dsh_r);
    bity  = (remy_r >= dsh_r);
    offx  = negx_r ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r});
    offy  = negy_r ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});
    hdx   = 17'(hx_r) - 17'(hit_x_r);
    hdy   = 17'(hy_r) - 17'(hit_y_r);
    fdx   = 17'(hx_r) - 17'(fk_x_r);
    fdy   = 17'(hy_r) - 17'(fk_y_r);
    hdx2  = hdx * hdx;
    hdy2  = hdy * hdy;
    fdx2  = fdx * fdx;
    fdy2  = fdy * fdy;
    hsum  = 35'(unsigned'(hdx2)) + 35'(unsigned'(hdy2));
    fsum  = 35'(unsigned'(fdx2)) + 35'(unsigned'(fdy2));
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    cur_nxt        = cur_r;
    s_nxt          = s_r;
    rej_nxt        = rej_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    magx_nxt       = magx_r;
    magy_nxt       = magy_r;
    negx_nxt       = negx_r;
    negy_nxt       = negy_r;
    remx_nxt       = remx_r;
    remy_nxt       = remy_r;
    dsh_nxt        = dsh_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    cnt_nxt        = cnt_r;
    hv_nxt         = hv_r;
    hx_nxt         = hx_r;
    hy_nxt         = hy_r;
    closeh_nxt     = closeh_r;
    closef_nxt     = closef_r;
    pend_x_nxt     = pend_x_r;
    pend_y_nxt     = pend_y_r;
    have_pend_nxt  = have_pend_r;
    fk_x_nxt       = fk_x_r;
    fk_y_nxt       = fk_y_r;
    have_first_nxt = have_first_r;
    kt_nxt         = kt_r;
    hit_x_nxt      = hit_x_r;
    hit_y_nxt      = hit_y_r;
    have_hit_nxt   = have_hit_r;
    res_nxt        = res_r;
    res_n_nxt      = res_n_r;
    res_i_nxt      = res_i_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    pop            = 1'b0;
    n36            = '0;
    d36            = '0;
    keep           = 1'b0;
    new_em         = 1'b0;
    t_have_pend    = have_pend_r;
    t_kt           = kt_r;
    n              = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (fifo_valid) begin
          pop      = 1'b1;
          cur_nxt  = fifo_data;
          rej_nxt  = 1'b0;
          step_nxt = '0;
          hv_nxt   = 1'b0;
          if (fifo_data.first) begin
            have_pend_nxt  = 1'b0;
            have_first_nxt = 1'b0;
            kt_nxt         = '0;
            have_hit_nxt   = 1'b0;
            hit_x_nxt      = '0;
            hit_y_nxt      = '0;
            fk_x_nxt       = '0;
            fk_y_nxt       = '0;
          end
          state_nxt = fifo_data.has_edge ? ST_SIDE : ST_DEC;
        end
      end
      ST_SIDE: begin
        s_nxt[step_r] = side_val;
        step_nxt      = step_r + 1'b1;
        if (step_r == 2'd3) begin
          state_nxt = ST_PROD;
          step_nxt  = '0;
        end
      end
      ST_PROD: begin
        if (prod_ge) begin
          rej_nxt = 1'b1;
        end
        step_nxt = step_r + 1'b1;
        if (step_r[0]) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        n36 = 36'(s_r[0]);
        d36 = 36'(s_r[0]) - 36'(s_r[1]);
        if (d36 < 0) begin
          n36 = -n36;
          d36 = -d36;
        end
        priority if (rej_r) begin
          state_nxt = ST_DEC;
        end else if (d36 == 0 || n36 <= 0) begin
          hx_nxt    = cfg.ax;
          hy_nxt    = cfg.ay;
          hv_nxt    = 1'b1;
          state_nxt = ST_FILT;
        end else if (n36 >= d36) begin
          hx_nxt    = cfg.bx;
          hy_nxt    = cfg.by;
          hv_nxt    = 1'b1;
          state_nxt = ST_FILT;
        end else begin
          num_nxt   = n36[SIDE_W-1:0];
          den_nxt   = d36[SIDE_W-1:0];
          state_nxt = ST_MULD;
        end
      end
      ST_MULD: begin
        negx_nxt  = prodx[52];
        negy_nxt  = prody[52];
        magx_nxt  = prodx[52] ? 52'(-prodx) : 52'(prodx);
        magy_nxt  = prody[52] ? 52'(-prody) : 52'(prody);
        state_nxt = ST_DIVI;
      end
      ST_DIVI: begin
        remx_nxt  = 53'(magx_r) + 53'(den_r[SIDE_W-1:1]);
        remy_nxt  = 53'(magy_r) + 53'(den_r[SIDE_W-1:1]);
        dsh_nxt   = {2'b00, den_r, 16'h0000};
        qx_nxt    = '0;
        qy_nxt    = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (bitx) begin
          remx_nxt = remx_r - dsh_r;
        end
        if (bity) begin
          remy_nxt = remy_r - dsh_r;
        end
        qx_nxt  = {qx_r[Q_W-2:0], bitx};
        qy_nxt  = {qy_r[Q_W-2:0], bity};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(Q_W - 1)) begin
          state_nxt = ST_DIVF;
        end
      end
      ST_DIVF: begin
        hx_nxt    = 16'(18'(cfg.ax) + offx);
        hy_nxt    = 16'(18'(cfg.ay) + offy);
        hv_nxt    = 1'b1;
        state_nxt = ST_FILT;
      end
      ST_FILT: begin
        closeh_nxt = (hsum < 35'(cfg.join_eps_sq));
        closef_nxt = (fsum < 35'(cfg.join_eps_sq));
        state_nxt  = ST_DEC;
      end
      ST_DEC: begin
        res_nxt[0] = mk_res('0, '0, 1'b0, '0, 1'b0);
        res_nxt[1] = mk_res('0, '0, 1'b0, '0, 1'b0);
        if (hv_r) begin
          keep         = !have_hit_r || !closeh_r;
          hit_x_nxt    = hx_r;
          hit_y_nxt    = hy_r;
          have_hit_nxt = 1'b1;
          if (keep) begin
            if (t_kt != COUNT_MAX) begin
              t_kt = t_kt + 1'b1;
            end
            if (t_have_pend) begin
              res_nxt[n[0]] = mk_res(pend_x_r, pend_y_r, 1'b1, '0, 1'b0);
              n             = n + 1'b1;
              t_have_pend   = 1'b0;
            end
            priority if (!have_first_r) begin
              fk_x_nxt       = hx_r;
              fk_y_nxt       = hy_r;
              have_first_nxt = 1'b1;
              res_nxt[n[0]]  = mk_res(hx_r, hy_r, 1'b1, '0, 1'b0);
              n              = n + 1'b1;
              new_em         = 1'b1;
            end else if (closef_r) begin
              pend_x_nxt  = hx_r;
              pend_y_nxt  = hy_r;
              t_have_pend = 1'b1;
            end else begin
              res_nxt[n[0]] = mk_res(hx_r, hy_r, 1'b1, '0, 1'b0);
              n             = n + 1'b1;
              new_em        = 1'b1;
            end
          end
        end
        if (cur_r.last) begin
          if (t_have_pend) begin
            t_have_pend = 1'b0;
            if (t_kt != '0) begin
              t_kt = t_kt - 1'b1;
            end
          end
          if (n == 2'd2 && new_em) begin
            res_nxt[1].count = t_kt;
            res_nxt[1].last  = 1'b1;
          end else begin
            res_nxt[n[0]] = mk_res('0, '0, 1'b0, t_kt, 1'b1);
            n             = n + 1'b1;
          end
          t_kt           = '0;
          have_first_nxt = 1'b0;
          have_hit_nxt   = 1'b0;
          hit_x_nxt      = '0;
          hit_y_nxt      = '0;
          fk_x_nxt       = '0;
          fk_y_nxt       = '0;
        end
        have_pend_nxt = t_have_pend;
        kt_nxt        = t_kt;
        res_n_nxt     = n;
        res_i_nxt     = '0;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (res_i_r == res_n_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          out_nxt       = res_r[res_i_r[0]];
          out_valid_nxt = 1'b1;
          res_i_nxt     = res_i_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= '0;
      rej_r        <= 1'b0;
      hv_r         <= 1'b0;
      have_pend_r  <= 1'b0;
      pend_x_r     <= '0;
      pend_y_r     <= '0;
      have_first_r <= 1'b0;
      fk_x_r       <= '0;
      fk_y_r       <= '0;
      kt_r         <= '0;
      have_hit_r   <= 1'b0;
      hit_x_r      <= '0;
      hit_y_r      <= '0;
      res_n_r      <= '0;
      res_i_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      step_r       <= step_nxt;
      rej_r        <= rej_nxt;
      hv_r         <= hv_nxt;
      have_pend_r  <= have_pend_nxt;
      pend_x_r     <= pend_x_nxt;
      pend_y_r     <= pend_y_nxt;
      have_first_r <= have_first_nxt;
      fk_x_r       <= fk_x_nxt;
      fk_y_r       <= fk_y_nxt;
      kt_r         <= kt_nxt;
      have_hit_r   <= have_hit_nxt;
      hit_x_r      <= hit_x_nxt;
      hit_y_r      <= hit_y_nxt;
      res_n_r      <= res_n_nxt;
      res_i_r      <= res_i_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    s_r      <= s_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    magx_r   <= magx_nxt;
    magy_r   <= magy_nxt;
    negx_r   <= negx_nxt;
    negy_r   <= negy_nxt;
    remx_r   <= remx_nxt;
    remy_r   <= remy_nxt;
    dsh_r    <= dsh_nxt;
    qx_r     <= qx_nxt;
    qy_r     <= qy_nxt;
    cnt_r    <= cnt_nxt;
    hx_r     <= hx_nxt;
    hy_r     <= hy_nxt;
    closeh_r <= closeh_nxt;
    closef_r <= closef_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/segment_polyline_intersect_stream_core.sv @@
// A vertex without an edge test goes from the queue straight to the decision and
// output states; an edge needing the divider first passes side tests and division.
// The back end takes one vertex at a time and its 17-step divider dominates; the
// two-entry queue lets the input side run ahead while the back end works or stalls.
// Reset: synchronous, active low; clears configuration, polyline state and
// all handshake state.
`default_nettype none
module segment_polyline_intersect_stream_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [sps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [15:0]              in_vertex_x,
  input  wire logic signed [15:0]              in_vertex_y,
  input  wire logic                            in_first_vertex,
  input  wire logic                            in_last_vertex,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [15:0]                   out_point_x,
  output logic signed [15:0]                   out_point_y,
  output logic                                 out_is_point,
  output logic [sps_pkg::COUNT_W-1:0]          out_point_count,
  output logic                                 out_last
);
  import sps_pkg::*;

  cfg_t  cfg_r;
  edge_t push_data, pop_data;
  logic  push, pop, fifo_full, fifo_valid;
  res_t  out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SEG_AX:      cfg_r.ax          <= cfg_wdata[15:0];
        CFG_SEG_AY:      cfg_r.ay          <= cfg_wdata[15:0];
        CFG_SEG_BX:      cfg_r.bx          <= cfg_wdata[15:0];
        CFG_SEG_BY:      cfg_r.by          <= cfg_wdata[15:0];
        CFG_CROSS_EPS:   cfg_r.cross_eps   <= cfg_wdata;
        CFG_JOIN_EPS_SQ: cfg_r.join_eps_sq <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  sps_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_vertex_x     (in_vertex_x),
    .in_vertex_y     (in_vertex_y),
    .in_first_vertex (in_first_vertex),
    .in_last_vertex  (in_last_vertex),
    .fifo_full       (fifo_full),
    .push            (push),
    .push_data       (push_data)
  );

  sps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (fifo_valid),
    .pop_data  (pop_data)
  );

  sps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_valid (fifo_valid),
    .fifo_data  (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_point_x     = out_res.x;
  assign out_point_y     = out_res.y;
  assign out_is_point    = out_res.is_point;
  assign out_point_count = out_res.count;
  assign out_last        = out_res.last;

`ifndef SYNTH
  a_marker_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_point |-> out_last)
    else $error("end marker without last");
  a_marker_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_point |-> (out_point_x == 16'sd0) && (out_point_y == 16'sd0))
    else $error("end marker carries coordinates");
  a_count_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_point_count == '0))
    else $error("count on a non-final result");
`endif

endmodule
`default_nettype wire
